// ===== rtl/fpbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpbc_pkg
// shared types and constants of the frustum point and box cull core
// ----------------------------------------------------------------------------
package fpbc_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int REG_COUNT   = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int COORD_W     = 20;
	localparam int COEF_W      = 12;
	localparam int OFS_W       = 28;
	localparam int MARGIN_W    = 19;
	localparam int PROD_W      = COEF_W + COORD_W;
	localparam int DIST_W      = 41;
	localparam int FRAC_ALIGN  = 10;

	typedef enum logic [1:0] {
		OP_POINT  = 2'd0,
		OP_MARGIN = 2'd1,
		OP_BOX    = 2'd2,
		OP_GROUP  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [COORD_W-1:0]  ax;
		logic signed [COORD_W-1:0]  ay;
		logic signed [COORD_W-1:0]  az;
		logic signed [COORD_W-1:0]  bx;
		logic signed [COORD_W-1:0]  by;
		logic signed [COORD_W-1:0]  bz;
		logic [MARGIN_W-1:0]        margin;
		logic                       last;
		logic                       pass;
	} item_t;

endpackage

// ===== rtl/fpbc_cell.sv =====
// ----------------------------------------------------------------------------
// fpbc_cell
// one plane of the chain: holds the plane word, tests the word against it
// in two stages (products, then sum and sign) and hands it to the next cell
// ----------------------------------------------------------------------------
module fpbc_cell
	import fpbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  plane_we,
	input  logic [CFG_DATA_W-1:0] plane_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  item_t                 in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output item_t                 out_item
);

	logic [CFG_DATA_W-1:0]     plane_q;
	logic signed [COEF_W-1:0]  coef_a, coef_b, coef_c;
	logic signed [OFS_W-1:0]   ofs_d;
	logic signed [COORD_W-1:0] cx, cy, cz;
	logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
	logic signed [PROD_W-1:0]  prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [DIST_W-1:0]  dist_sum;
	item_t                     item_s1, item_s2;
	item_t                     item_next;
	logic                      v_s1, v_s2;
	logic                      ready_s1, ready_s2;
	logic                      is_box;

	assign coef_a = plane_q[11:0];
	assign coef_b = plane_q[23:12];
	assign coef_c = plane_q[35:24];
	assign ofs_d  = plane_q[63:36];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (plane_we) begin
			plane_q <= plane_data;
		end
	end

	// box: the corner farthest in front of the plane decides
	assign is_box = (in_item.op == OP_BOX);

	always_comb begin
		cx = in_item.ax;
		cy = in_item.ay;
		cz = in_item.az;
		if (is_box) begin
			if (coef_a[COEF_W-1] ? (in_item.bx < in_item.ax) : (in_item.bx > in_item.ax))
				cx = in_item.bx;
			if (coef_b[COEF_W-1] ? (in_item.by < in_item.ay) : (in_item.by > in_item.ay))
				cy = in_item.by;
			if (coef_c[COEF_W-1] ? (in_item.bz < in_item.az) : (in_item.bz > in_item.az))
				cz = in_item.bz;
		end
	end

	assign prod_x = PROD_W'(coef_a) * PROD_W'(cx);
	assign prod_y = PROD_W'(coef_b) * PROD_W'(cy);
	assign prod_z = PROD_W'(coef_c) * PROD_W'(cz);

	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				v_s1 <= in_valid;
			if (ready_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			item_s1   <= in_item;
			prod_x_s1 <= prod_x;
			prod_y_s1 <= prod_y;
			prod_z_s1 <= prod_z;
		end
	end

	// distance at fraction 18, margin already zero unless margin mode
	assign dist_sum = DIST_W'(prod_x_s1) + DIST_W'(prod_y_s1) + DIST_W'(prod_z_s1)
		+ DIST_W'($signed({ofs_d, {FRAC_ALIGN{1'b0}}}))
		+ DIST_W'({item_s1.margin, {FRAC_ALIGN{1'b0}}});

	always_comb begin
		item_next      = item_s1;
		item_next.pass = item_s1.pass && !dist_sum[DIST_W-1];
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			item_s2 <= item_next;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

`ifndef SYNTHESIS
	a_hold_s2 : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out_ready) |=> v_s2)
		else $error("cell dropped a held word");
	a_full_when_blocked : assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2))
		else $error("cell blocked with a free stage");
	a_pass_monotone : assert property (@(posedge clk) disable iff (!arst_n)
		(ready_s2 && v_s1 && !item_s1.pass) |=> !item_s2.pass)
		else $error("cell revived a rejected word");
`endif

endmodule

// ===== rtl/frustum_point_box_cull_core.sv =====
// ----------------------------------------------------------------------------
// frustum_point_box_cull_core
// six plane frustum cull of points, margin points, boxes and point groups
// ----------------------------------------------------------------------------
// path: each plane cell holds two stages, the first loaded at accept, and the last cell
// feeds the output register
// throughput: one word per cycle while out_stall is low, set by the chain of plane cells, two
// stages each, with per stage valid so bubbles close up under stall
// reset: clears the plane registers, the group flag and all valid bits
// ----------------------------------------------------------------------------
module frustum_point_box_cull_core
	import fpbc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 operation,
	input  logic signed [COORD_W-1:0]  corner_a_x,
	input  logic signed [COORD_W-1:0]  corner_a_y,
	input  logic signed [COORD_W-1:0]  corner_a_z,
	input  logic signed [COORD_W-1:0]  corner_b_x,
	input  logic signed [COORD_W-1:0]  corner_b_y,
	input  logic signed [COORD_W-1:0]  corner_b_z,
	input  logic [MARGIN_W-1:0]        margin,
	input  logic                       last_in_group,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       visible,
	output logic [1:0]                 operation_echo
);

	logic [PLANE_COUNT:0] chain_valid;
	logic [PLANE_COUNT:0] chain_ready;
	item_t                chain_item [PLANE_COUNT+1];
	item_t                head;
	item_t                fin;
	logic                 fin_fire;
	logic                 grp_any_q;
	logic                 out_valid_q;
	logic                 visible_q;
	op_t                  echo_q;
	logic                 grp_vis;

	always_comb begin
		head.op     = op_t'(operation);
		head.ax     = corner_a_x;
		head.ay     = corner_a_y;
		head.az     = corner_a_z;
		head.bx     = corner_b_x;
		head.by     = corner_b_y;
		head.bz     = corner_b_z;
		head.margin = (op_t'(operation) == OP_MARGIN) ? margin : '0;
		head.last   = last_in_group;
		head.pass   = 1'b1;
	end

	assign chain_valid[0] = in_valid;
	assign chain_item[0]  = head;
	assign in_stall       = !chain_ready[0];

	for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
		fpbc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.plane_we   (cfg_we && (cfg_index == CFG_IDX_W'(i))),
			.plane_data (cfg_data),
			.in_valid   (chain_valid[i]),
			.in_ready   (chain_ready[i]),
			.in_item    (chain_item[i]),
			.out_valid  (chain_valid[i+1]),
			.out_ready  (chain_ready[i+1]),
			.out_item   (chain_item[i+1])
		);
	end

	assign fin                      = chain_item[PLANE_COUNT];
	assign chain_ready[PLANE_COUNT] = !out_valid_q || !out_stall;
	assign fin_fire                 = chain_valid[PLANE_COUNT] && chain_ready[PLANE_COUNT];
	assign grp_vis                  = grp_any_q || fin.pass;

	// group words fold into the flag, only the last one gives a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			grp_any_q   <= 1'b0;
		end else begin
			if (chain_ready[PLANE_COUNT])
				out_valid_q <= chain_valid[PLANE_COUNT] && (fin.op != OP_GROUP || fin.last);
			if (fin_fire && fin.op == OP_GROUP)
				grp_any_q <= fin.last ? 1'b0 : grp_vis;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			visible_q <= (fin.op == OP_GROUP) ? grp_vis : fin.pass;
			echo_q    <= fin.op;
		end
	end

	assign out_valid      = out_valid_q;
	assign visible        = visible_q;
	assign operation_echo = echo_q;

`ifndef SYNTHESIS
	a_group_clear : assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && fin.op == OP_GROUP && fin.last) |=> !grp_any_q)
		else $error("group flag not cleared after group result");
	a_group_untouched : assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && fin.op != OP_GROUP) |=> $stable(grp_any_q))
		else $error("group flag changed by a non group word");
	a_result_held : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(visible_q)))
		else $error("stalled result lost");
	a_no_mid_group_result : assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && fin.op == OP_GROUP && !fin.last) |=> !out_valid_q)
		else $error("result from a word inside a group");
`endif

endmodule
